// ----- rtl/button_debounce_pot_servo_tracker_macros.svh -----
// Assertion macros shared by the tracker RTL.
`ifndef BUTTON_DEBOUNCE_POT_SERVO_TRACKER_MACROS_SVH
`define BUTTON_DEBOUNCE_POT_SERVO_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define BDST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tracker assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define BDST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tracker assertion failed");
`else
`define BDST_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BDST_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/bdst_pkg.sv -----
// Shared types and constants of the button debounce and servo tracker.
package bdst_pkg;

    localparam int BTN_FIELD_W  = 5;
    localparam int ADC_BITS     = 12;
    localparam int STAMP_W      = 32;
    localparam int ANGLE_W      = 8;
    localparam int PCT_W        = 7;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int DEADBAND_W   = 8;

    localparam int ANGLE_FULL   = 180;
    localparam int ANGLE_CENTER = 90;
    localparam int PERCENT_FULL = 100;

    // Widths of mean * 100 and mean * 180 for a 12-bit mean.
    localparam int PCT_PROD_W   = 19;
    localparam int ANG_PROD_W   = 20;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 2'd2;

    typedef logic [BTN_FIELD_W-1:0] btn_t;
    typedef logic [ADC_BITS-1:0]    sample_t;
    typedef logic [STAMP_W-1:0]     stamp_t;
    typedef logic [ANGLE_W-1:0]     angle_t;
    typedef logic [PCT_W-1:0]       pct_t;
    typedef logic [CFG_DATA_W-1:0]  cfg_word_t;
    typedef logic [DEADBAND_W-1:0]  deadband_t;

    // Ring memory control: read at acceptance, write when the first stage retires.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } ring_ctl_t;

endpackage

// ----- rtl/bdst_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bdst_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // Hold read data until the next read; a same-address write returns old data.
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/bdst_debounce.sv -----
// Per-button debounce timers, debounced state and sticky press flags.
module bdst_debounce #(
    parameter int BUTTON_COUNT = 5
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  bdst_pkg::btn_t         levels,
    input  bdst_pkg::btn_t         clear,
    input  bdst_pkg::stamp_t       now_ms,
    input  bdst_pkg::cfg_word_t    debounce_ms,
    output bdst_pkg::btn_t         stable,
    output bdst_pkg::btn_t         flags
);
    import bdst_pkg::*;

    // Buttons beyond the input field never press, so they get no lane.
    localparam int LANES = (BUTTON_COUNT < BTN_FIELD_W) ? BUTTON_COUNT : BTN_FIELD_W;

    logic [LANES-1:0] pressed_raw;
    logic [LANES-1:0] raw_prev_reg;
    logic [LANES-1:0] stable_reg;
    logic [LANES-1:0] stable_next;
    logic [LANES-1:0] sticky_reg;
    logic [LANES-1:0] sticky_next;
    logic [LANES-1:0] flags_mid;
    stamp_t           stamp_reg  [LANES];
    stamp_t           stamp_next [LANES];
    stamp_t           elapsed    [LANES];

    assign pressed_raw = ~levels[LANES-1:0];

    always_comb
    begin
        stable_next = stable_reg;
        flags_mid   = sticky_reg;
        for (int i = 0; i < LANES; i++)
        begin
            // Restart the timer on any raw change.
            stamp_next[i] = (pressed_raw[i] != raw_prev_reg[i]) ? now_ms : stamp_reg[i];
            elapsed[i]    = now_ms - stamp_next[i];
            if (elapsed[i] > STAMP_W'(debounce_ms) && pressed_raw[i] != stable_reg[i])
            begin
                stable_next[i] = pressed_raw[i];
                if (pressed_raw[i])
                begin
                    flags_mid[i] = 1'b1;
                end
            end
        end
        sticky_next = flags_mid & ~clear[LANES-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_prev_reg <= '0;
            stable_reg   <= '0;
            sticky_reg   <= '0;
            for (int i = 0; i < LANES; i++)
            begin
                stamp_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            raw_prev_reg <= pressed_raw;
            stable_reg   <= stable_next;
            sticky_reg   <= sticky_next;
            for (int i = 0; i < LANES; i++)
            begin
                stamp_reg[i] <= stamp_next[i];
            end
        end
    end

    assign stable = btn_t'(stable_next);
    assign flags  = btn_t'(flags_mid);

endmodule

// ----- rtl/bdst_ring.sv -----
// Sample ring in RAM with per-entry valid bits, write forwarding and running sum.
module bdst_ring #(
    parameter int AVG_DEPTH = 8,
    parameter int SUM_W     = bdst_pkg::ADC_BITS + $clog2(AVG_DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bdst_pkg::ring_ctl_t ctl,
    input  bdst_pkg::sample_t   wr_data,
    output logic [SUM_W-1:0]    sum_next
);
    import bdst_pkg::*;

    localparam int            AW   = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(AVG_DEPTH - 1);

    logic [AW-1:0]        rd_ptr_reg;
    logic [AW-1:0]        wr_ptr_reg;
    logic [AVG_DEPTH-1:0] vld_reg;
    logic                 old_vld_reg;
    logic                 fwd_reg;
    sample_t              fwd_data_reg;
    sample_t              rd_data;
    sample_t              old_sample;
    logic [SUM_W-1:0]     sum_reg;

    bdst_ram #(
        .WIDTH (ADC_BITS),
        .DEPTH (AVG_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ctl.wr_en),
        .waddr (wr_ptr_reg),
        .wdata (wr_data),
        .re    (ctl.rd_en),
        .raddr (rd_ptr_reg),
        .rdata (rd_data)
    );

    // Entry leaving the ring: forwarded write, stored sample, or zero if never written.
    assign old_sample = fwd_reg ? fwd_data_reg : (old_vld_reg ? rd_data : '0);
    assign sum_next   = sum_reg - SUM_W'(old_sample) + SUM_W'(wr_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg  <= '0;
            wr_ptr_reg  <= '0;
            vld_reg     <= '0;
            old_vld_reg <= 1'b0;
            fwd_reg     <= 1'b0;
            sum_reg     <= '0;
        end
        else
        begin
            if (ctl.rd_en)
            begin
                rd_ptr_reg  <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
                old_vld_reg <= vld_reg[rd_ptr_reg];
                fwd_reg     <= ctl.wr_en && (wr_ptr_reg == rd_ptr_reg);
            end
            if (ctl.wr_en)
            begin
                wr_ptr_reg          <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
                vld_reg[wr_ptr_reg] <= 1'b1;
                sum_reg             <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            fwd_data_reg <= wr_data;
        end
    end

endmodule

// ----- rtl/bdst_servo.sv -----
// Servo angle state: interval timer and deadband check against the last move.
module bdst_servo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  bdst_pkg::angle_t    target,
    input  bdst_pkg::stamp_t    now_ms,
    input  bdst_pkg::cfg_word_t interval_ms,
    input  bdst_pkg::deadband_t deadband_deg,
    output bdst_pkg::angle_t    angle,
    output logic                moved
);
    import bdst_pkg::*;

    // Commanded angle and last pot angle always move together: one register.
    angle_t angle_reg;
    stamp_t stamp_reg;
    stamp_t elapsed;
    angle_t diff;
    logic   due;

    assign elapsed = now_ms - stamp_reg;
    assign due     = elapsed >= STAMP_W'(interval_ms);
    assign diff    = (target > angle_reg) ? (target - angle_reg) : (angle_reg - target);
    assign moved   = due && (diff > deadband_deg);
    assign angle   = moved ? target : angle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg <= ANGLE_W'(ANGLE_CENTER);
            stamp_reg <= '0;
        end
        else if (fire && moved)
        begin
            angle_reg <= target;
            stamp_reg <= now_ms;
        end
    end

endmodule

// ----- rtl/button_debounce_pot_servo_tracker.sv -----
// Button debounce and potentiometer servo tracker top level.
//
// One beat per update tick: five active-low button levels, a 12-bit pot sample,
// a millisecond timestamp and a press-clear mask go in; one result beat comes
// out with the debounced buttons, the sticky press flags (before this beat's
// clear), the moving average of the pot, its 0..100 percent scale, the servo
// angle and whether the servo moved. The block takes one beat per clock cycle
// while out_ready keeps results flowing. The pot samples live in a RAM of
// AVG_DEPTH entries read when a beat is accepted and written as the beat leaves
// the first stage, when the running sum and the debounce state take their
// read-modify-write step; the mean, the percent/angle scaling and the servo
// check follow in three more stages, the servo check ending in the output
// register. Stalls from out_ready ripple back stage by stage, so new beats
// keep entering while a finished result waits. Ring entries carry valid bits
// cleared at reset, so the ring reads as all zero at start and no clearing
// pass is needed. Configuration is taken any cycle through cfg_valid with
// cfg_ready always high; an index beyond the register list is dropped.
`include "button_debounce_pot_servo_tracker_macros.svh"

module button_debounce_pot_servo_tracker #(
    parameter int AVG_DEPTH    = 8,
    parameter int BUTTON_COUNT = 5
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [bdst_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  bdst_pkg::cfg_word_t                    cfg_data,

    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  bdst_pkg::btn_t                         button_levels,
    input  bdst_pkg::sample_t                      adc_sample,
    input  bdst_pkg::stamp_t                       now_ms,
    input  bdst_pkg::btn_t                         clear_press,

    output logic                                   out_valid,
    input  logic                                   out_ready,
    output bdst_pkg::btn_t                         stable_buttons,
    output bdst_pkg::btn_t                         press_flags,
    output bdst_pkg::sample_t                      smoothed_value,
    output bdst_pkg::pct_t                         level_percent,
    output bdst_pkg::angle_t                       servo_angle,
    output logic                                   servo_moved
);
    import bdst_pkg::*;

    // Mean = sum / AVG_DEPTH as an exact reciprocal multiply over the sum's range.
    localparam int AVG_LOG  = $clog2(AVG_DEPTH);
    localparam int SUM_W    = ADC_BITS + AVG_LOG;
    localparam int MEAN_SH  = SUM_W + AVG_LOG;
    localparam int MEAN_MW  = SUM_W + 1;
    localparam int PROD_W   = 2 * SUM_W + 1;
    localparam logic [MEAN_MW-1:0] MEAN_M =
        MEAN_MW'(((64'd1 << MEAN_SH) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));
    localparam int DIV_W    = ANG_PROD_W + 1;

    // Divide by the full-scale code 2^12 - 1: exact while the quotient stays below 2^12.
    function automatic logic [DIV_W-1:0] div_full(input logic [DIV_W-1:0] x);
        return (x + (x >> ADC_BITS) + 1'b1) >> ADC_BITS;
    endfunction

    // ---------------- configuration ----------------
    cfg_word_t debounce_ms_reg;
    cfg_word_t interval_ms_reg;
    deadband_t deadband_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg <= 16'd50;
            interval_ms_reg <= 16'd20;
            deadband_reg    <= 8'd2;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE: debounce_ms_reg <= cfg_data;
                CFG_INTERVAL: interval_ms_reg <= cfg_data;
                CFG_DEADBAND: deadband_reg    <= cfg_data[DEADBAND_W-1:0];
                default:      ;
            endcase
        end
    end

    // ---------------- stage handshake ----------------
    // Each stage advances when occupied and the next one can take its beat.
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy_o;
    logic adv1, adv2, adv3, adv4;
    logic in_accept;

    assign rdy_o     = !out_valid_reg || out_ready;
    assign adv4      = v4_reg && rdy_o;
    assign rdy4      = !v4_reg || rdy_o;
    assign adv3      = v3_reg && rdy4;
    assign rdy3      = !v3_reg || rdy4;
    assign adv2      = v2_reg && rdy3;
    assign rdy2      = !v2_reg || rdy3;
    assign adv1      = v1_reg && rdy2;
    assign rdy1      = !v1_reg || rdy2;
    assign in_ready  = rdy1;
    assign in_accept = in_valid && rdy1;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                v1_reg <= 1'b1;
            else if (adv1)
                v1_reg <= 1'b0;
            if (adv1)
                v2_reg <= 1'b1;
            else if (adv2)
                v2_reg <= 1'b0;
            if (adv2)
                v3_reg <= 1'b1;
            else if (adv3)
                v3_reg <= 1'b0;
            if (adv3)
                v4_reg <= 1'b1;
            else if (adv4)
                v4_reg <= 1'b0;
            if (adv4)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------- stage 1: ring read data, debounce, running sum ----------------
    btn_t             s1_levels_reg;
    btn_t             s1_clear_reg;
    sample_t          s1_sample_reg;
    stamp_t           s1_now_reg;
    ring_ctl_t        ring_ctl;
    logic [SUM_W-1:0] ring_sum;
    btn_t             db_stable;
    btn_t             db_flags;

    // Read the leaving entry as the beat arrives; write the new sample over it as the beat retires.
    assign ring_ctl.rd_en = in_accept;
    assign ring_ctl.wr_en = adv1;

    bdst_ring #(
        .AVG_DEPTH (AVG_DEPTH),
        .SUM_W     (SUM_W)
    ) u_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ring_ctl),
        .wr_data  (s1_sample_reg),
        .sum_next (ring_sum)
    );

    bdst_debounce #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_debounce (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (adv1),
        .levels      (s1_levels_reg),
        .clear       (s1_clear_reg),
        .now_ms      (s1_now_reg),
        .debounce_ms (debounce_ms_reg),
        .stable      (db_stable),
        .flags       (db_flags)
    );

    // ---------------- stage 2: mean ----------------
    logic [SUM_W-1:0]  s2_sum_reg;
    btn_t              s2_stable_reg;
    btn_t              s2_flags_reg;
    stamp_t            s2_now_reg;
    logic [PROD_W-1:0] mean_prod;
    sample_t           mean;

    assign mean_prod = PROD_W'(s2_sum_reg) * PROD_W'(MEAN_M);
    assign mean      = mean_prod[MEAN_SH +: ADC_BITS];

    // ---------------- stage 3: scale by 100 and 180 ----------------
    sample_t                s3_mean_reg;
    btn_t                   s3_stable_reg;
    btn_t                   s3_flags_reg;
    stamp_t                 s3_now_reg;
    logic [PCT_PROD_W-1:0]  pct_prod;
    logic [ANG_PROD_W-1:0]  ang_prod;

    assign pct_prod = PCT_PROD_W'(s3_mean_reg) * PCT_PROD_W'(PERCENT_FULL);
    assign ang_prod = ANG_PROD_W'(s3_mean_reg) * ANG_PROD_W'(ANGLE_FULL);

    // ---------------- stage 4: divide by full scale, servo decision ----------------
    sample_t                s4_mean_reg;
    btn_t                   s4_stable_reg;
    btn_t                   s4_flags_reg;
    stamp_t                 s4_now_reg;
    logic [PCT_PROD_W-1:0]  s4_pct_prod_reg;
    logic [ANG_PROD_W-1:0]  s4_ang_prod_reg;
    logic [DIV_W-1:0]       pct_quot;
    logic [DIV_W-1:0]       ang_quot;
    pct_t                   percent;
    angle_t                 target;
    angle_t                 servo_angle_next;
    logic                   servo_moved_next;

    assign pct_quot = div_full(DIV_W'(s4_pct_prod_reg));
    assign ang_quot = div_full(DIV_W'(s4_ang_prod_reg));
    assign percent  = pct_quot[PCT_W-1:0];
    // Clamp to full travel.
    assign target   = (ang_quot > DIV_W'(ANGLE_FULL)) ? ANGLE_W'(ANGLE_FULL)
                                                      : ang_quot[ANGLE_W-1:0];

    bdst_servo u_servo (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (adv4),
        .target       (target),
        .now_ms       (s4_now_reg),
        .interval_ms  (interval_ms_reg),
        .deadband_deg (deadband_reg),
        .angle        (servo_angle_next),
        .moved        (servo_moved_next)
    );

    // ---------------- payload registers ----------------
    btn_t    out_stable_reg;
    btn_t    out_flags_reg;
    sample_t out_mean_reg;
    pct_t    out_percent_reg;
    angle_t  out_angle_reg;
    logic    out_moved_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_levels_reg <= button_levels;
            s1_clear_reg  <= clear_press;
            s1_sample_reg <= adc_sample;
            s1_now_reg    <= now_ms;
        end
        if (adv1)
        begin
            s2_sum_reg    <= ring_sum;
            s2_stable_reg <= db_stable;
            s2_flags_reg  <= db_flags;
            s2_now_reg    <= s1_now_reg;
        end
        if (adv2)
        begin
            s3_mean_reg   <= mean;
            s3_stable_reg <= s2_stable_reg;
            s3_flags_reg  <= s2_flags_reg;
            s3_now_reg    <= s2_now_reg;
        end
        if (adv3)
        begin
            s4_mean_reg     <= s3_mean_reg;
            s4_stable_reg   <= s3_stable_reg;
            s4_flags_reg    <= s3_flags_reg;
            s4_now_reg      <= s3_now_reg;
            s4_pct_prod_reg <= pct_prod;
            s4_ang_prod_reg <= ang_prod;
        end
        if (adv4)
        begin
            out_stable_reg  <= s4_stable_reg;
            out_flags_reg   <= s4_flags_reg;
            out_mean_reg    <= s4_mean_reg;
            out_percent_reg <= percent;
            out_angle_reg   <= servo_angle_next;
            out_moved_reg   <= servo_moved_next;
        end
    end

    assign stable_buttons = out_stable_reg;
    assign press_flags    = out_flags_reg;
    assign smoothed_value = out_mean_reg;
    assign level_percent  = out_percent_reg;
    assign servo_angle    = out_angle_reg;
    assign servo_moved    = out_moved_reg;

    // ---------------- assertions ----------------
    // Input can only stall when every stage is full behind a held result.
    `BDST_ASSERT_IMP(a_stall_cause, clk, rst_n, !in_ready, v1_reg && v2_reg && v3_reg && v4_reg && out_valid_reg && !out_ready)
    // An accepted beat always occupies the first stage next cycle.
    `BDST_ASSERT_NXT(a_accept_lands, clk, rst_n, in_valid && in_ready, v1_reg)
    // Delivered angle and percent stay within their scales.
    `BDST_ASSERT_IMP(a_angle_range, clk, rst_n, out_valid, servo_angle <= ANGLE_W'(ANGLE_FULL))
    `BDST_ASSERT_IMP(a_pct_range, clk, rst_n, out_valid, level_percent <= PCT_W'(PERCENT_FULL))

endmodule
